// ===== hdl/dsdd_pkg.sv =====
// Package for the serial display driver: command codes, widths, the
// digit state and input word structures and the segment bit tables.
// Depends on nothing; every other file of the block but dsdd_out_if uses it.
package dsdd_pkg;

  localparam int PATTERN_BITS = 48;
  localparam int DIGIT_COUNT  = 4;
  localparam int NUM_CODES    = 12;
  localparam int CMD_W        = 3;
  localparam int DIGIT_W      = 2;
  localparam int VALUE_W      = 4;
  localparam int POS_W        = $clog2(PATTERN_BITS);
  localparam int CNT_W        = $clog2(PATTERN_BITS);

  typedef enum logic [CMD_W-1:0] {
    CMD_SET     = 3'd0,
    CMD_ENABLE  = 3'd1,
    CMD_DISABLE = 3'd2,
    CMD_EN_ALL  = 3'd3,
    CMD_DIS_ALL = 3'd4,
    CMD_UPDATE  = 3'd5
  } cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_SHIFT
  } shift_state_t;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [DIGIT_W-1:0] digit;
    logic [VALUE_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic [DIGIT_COUNT-1:0][VALUE_W-1:0] value;
    logic [DIGIT_COUNT-1:0]              enable;
  } disp_state_t;

  function automatic logic [POS_W-1:0] pos_even(input logic [VALUE_W-1:0] v);
    logic [POS_W-1:0] p;
    case (v)
      4'd0:    p = 6'd5;
      4'd1:    p = 6'd14;
      4'd2:    p = 6'd15;
      4'd3:    p = 6'd13;
      4'd4:    p = 6'd12;
      4'd5:    p = 6'd0;
      4'd6:    p = 6'd1;
      4'd7:    p = 6'd2;
      4'd8:    p = 6'd3;
      4'd9:    p = 6'd4;
      4'd10:   p = 6'd7;
      4'd11:   p = 6'd6;
      default: p = 6'd0;
    endcase
    return p;
  endfunction

  function automatic logic [POS_W-1:0] pos_odd(input logic [VALUE_W-1:0] v);
    logic [POS_W-1:0] p;
    case (v)
      4'd0:    p = 6'd10;
      4'd1:    p = 6'd17;
      4'd2:    p = 6'd16;
      4'd3:    p = 6'd18;
      4'd4:    p = 6'd19;
      4'd5:    p = 6'd23;
      4'd6:    p = 6'd22;
      4'd7:    p = 6'd21;
      4'd8:    p = 6'd20;
      4'd9:    p = 6'd11;
      4'd10:   p = 6'd8;
      4'd11:   p = 6'd9;
      default: p = 6'd0;
    endcase
    return p;
  endfunction

  // Values of NUM_CODES (12) and above light nothing.
  function automatic logic [PATTERN_BITS-1:0] segment_word(
    input logic [DIGIT_W-1:0] d,
    input logic [VALUE_W-1:0] v
  );
    logic [POS_W-1:0] p;
    p = d[0] ? pos_odd(v) : pos_even(v);
    if (d[1]) begin
      p = p + POS_W'(24);
    end
    if (v >= VALUE_W'(NUM_CODES)) begin
      return '0;
    end
    return PATTERN_BITS'(1) << p;
  endfunction

endpackage

// ===== hdl/dsdd_in_if.sv =====
// Input channel of the serial display driver: valid, ready and the
// command word. Depends on dsdd_pkg for the field widths.
interface dsdd_in_if;
  logic                         valid;
  logic                         ready;
  logic [dsdd_pkg::CMD_W-1:0]   cmd;
  logic [dsdd_pkg::DIGIT_W-1:0] digit;
  logic [dsdd_pkg::VALUE_W-1:0] value;

  modport source (output valid, output cmd, output digit, output value, input ready);
  modport sink   (input valid, input cmd, input digit, input value, output ready);
endinterface

// ===== hdl/dsdd_out_if.sv =====
// Result channel of the serial display driver: valid, ready, the serial
// bit and the latch marker. Depends on nothing.
interface dsdd_out_if;
  logic valid;
  logic ready;
  logic serial_bit;
  logic latch;

  modport source (output valid, output serial_bit, output latch, input ready);
  modport sink   (input valid, input serial_bit, input latch, output ready);
endinterface

// ===== hdl/dsdd_regs.sv =====
// Digit value store and enable flags, updated by the accepted commands.
// Depends on dsdd_pkg.
module dsdd_regs (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_fire,
  input  dsdd_pkg::in_word_t    in_word,
  output dsdd_pkg::disp_state_t disp_state
);
  import dsdd_pkg::*;

  logic [DIGIT_COUNT-1:0][VALUE_W-1:0] value_r, value_nxt;
  logic [DIGIT_COUNT-1:0]              enable_r, enable_nxt;

  always_comb begin
    value_nxt  = value_r;
    enable_nxt = enable_r;
    if (in_fire) begin
      unique case (cmd_t'(in_word.cmd))
        CMD_SET:     value_nxt[in_word.digit] = in_word.value;
        CMD_ENABLE:  enable_nxt[in_word.digit] = 1'b1;
        CMD_DISABLE: enable_nxt[in_word.digit] = 1'b0;
        CMD_EN_ALL:  enable_nxt = '1;
        CMD_DIS_ALL: enable_nxt = '0;
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      value_r  <= '0;
      enable_r <= '1;
    end else begin
      value_r  <= value_nxt;
      enable_r <= enable_nxt;
    end
  end

  assign disp_state.value  = value_r;
  assign disp_state.enable = enable_r;

endmodule

// ===== hdl/dsdd_shifter.sv =====
// Builds the segment pattern on an update and shifts it out one bit per
// word, marking the last bit as the latch pulse. Depends on dsdd_pkg.
module dsdd_shifter (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  dsdd_pkg::disp_state_t disp_state,
  output logic                  in_ready,
  dsdd_out_if.source            out_if
);
  import dsdd_pkg::*;

  shift_state_t            state_r, state_nxt;
  logic [PATTERN_BITS-1:0] shift_r, shift_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [PATTERN_BITS-1:0] word;
  logic                    last;
  logic                    out_fire;

  always_comb begin
    word = '0;
    for (int i = 0; i < DIGIT_COUNT; i++) begin
      if (disp_state.enable[i]) begin
        word = word | segment_word(DIGIT_W'(i), disp_state.value[i]);
      end
    end
  end

  assign last     = (cnt_r == CNT_W'(PATTERN_BITS - 1));
  assign out_fire = out_if.valid && out_if.ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (load) state_nxt = ST_SHIFT;
      ST_SHIFT: if (out_fire && last) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    shift_nxt = shift_r;
    cnt_nxt   = cnt_r;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (load) begin
          shift_nxt = word;
          cnt_nxt   = '0;
        end
      end
      ST_SHIFT: begin
        if (out_fire) begin
          shift_nxt = {1'b0, shift_r[PATTERN_BITS-1:1]};
          cnt_nxt   = cnt_r + CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
  end

  assign out_if.valid      = (state_r == ST_SHIFT);
  assign out_if.serial_bit = shift_r[0];
  assign out_if.latch      = (state_r == ST_SHIFT) && last;

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> state_r == ST_IDLE)
    else $error("update loaded while a pattern was still shifting");

  a_load_start: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_if.valid && cnt_r == '0)
    else $error("pattern did not start at bit zero after an update");

  a_latch_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && out_if.latch |=> !out_if.valid && in_ready)
    else $error("shifting did not stop after the latch word");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && !out_if.ready |=> $stable(cnt_r) && $stable(shift_r))
    else $error("pattern advanced while the sink stalled");

endmodule

// ===== hdl/digit_to_serial_display_driver_core.sv =====
// Top level of the four-digit serial display driver.
// Depends on dsdd_pkg, dsdd_in_if, dsdd_out_if, dsdd_regs and dsdd_shifter.
//
// Commands set a digit value, enable or disable one digit or all digits,
// or update the display; all but update only change the stored state and
// produce no word. An update snapshots the four digits into a 48-bit
// segment pattern (1 means segment on, before any board inverter) and
// shifts it out bit 0 first, one word per cycle while the sink is ready;
// the 48th word carries latch. The input is held off for the 48 words of
// an update, until the pattern shift register and its bit counter have
// sent the latch word.
module digit_to_serial_display_driver_core (
  input  logic       clk,
  input  logic       rst_n,
  dsdd_in_if.sink    in_if,
  dsdd_out_if.source out_if
);
  import dsdd_pkg::*;

  in_word_t    in_word;
  disp_state_t disp_state;
  logic        in_fire;
  logic        load;

  assign in_word.cmd   = in_if.cmd;
  assign in_word.digit = in_if.digit;
  assign in_word.value = in_if.value;
  assign in_fire       = in_if.valid && in_if.ready;
  assign load          = in_fire && (in_if.cmd == CMD_UPDATE);

  dsdd_regs u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_fire),
    .in_word    (in_word),
    .disp_state (disp_state)
  );

  dsdd_shifter u_shifter (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (load),
    .disp_state (disp_state),
    .in_ready   (in_if.ready),
    .out_if     (out_if)
  );

endmodule
